[rtl/sapd_pkg.sv]
// Package for the suffix array prefix doubling unit.
// Holds sizes, request and result structs and status codes; no dependencies.
package sapd_pkg;
  localparam int MAX_TEXT = 1024;
  localparam int MAX_ALPHABET = 256;
  localparam int AW = 10;   // text address width
  localparam int RW = 11;   // rank / count width

  localparam logic [1:0] ST_READ_OK = 2'd0;
  localparam logic [1:0] ST_BUILD_DONE = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;
  localparam logic [1:0] ST_BAD_POS = 2'd3;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_READ = 1'b1;

  typedef struct packed {
    logic       req_type;
    logic [7:0] symbol_index;
    logic       is_last;
    logic [9:0] position;
  } req_t;

  typedef struct packed {
    logic [9:0]  suffix_start;
    logic [1:0]  status;
    logic [10:0] text_length;
  } rsp_t;
endpackage

[rtl/suffix_array_prefix_doubling_unit.sv]
// Top level of the suffix array prefix doubling unit.
// Depends on sapd_pkg; holds the sequencer and the four working memories.
//
// Usage: raise start with a request on req while busy is low. A load
// without the last mark and without overflow gives no result. A read of a
// loaded position gives one result on rsp, marked by done, after a memory
// read and then the result register; a read before the build has closed
// the text, or past its end, gives ST_BAD_POS without the memory read. A
// load marked last starts the build; busy stays high for the whole build
// and done pulses with the build status when it ends. One counting sort
// runs clear, count, prefix sum, scatter and copy back, with buckets up
// to top, where top is max(alphabet_size, n) in the first pass and n
// later. One pass at offset k is two sorts plus re-rank and rank copy;
// passes double k until all ranks are distinct or 2*k reaches n. The
// buckets, rank, order and scratch stores are single-port arrays, one
// access per cycle. The alphabet_size register is written on
// cfg_valid&cfg_ready; cfg_ready is always high. Reset clears loaded
// count, the closed flag, the sequencer and the alphabet size (back to
// 256). Memories need no clearing. The receiver cannot stall: each
// result is shown one cycle.
module suffix_array_prefix_doubling_unit (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  sapd_pkg::req_t req,
  output logic done,
  output sapd_pkg::rsp_t rsp,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [8:0] cfg_data
);
  import sapd_pkg::*;

  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_READ   = 14'b00000000000010,
    S_INIT   = 14'b00000000000100,
    S_CLR    = 14'b00000000001000,
    S_CNT    = 14'b00000000010000,
    S_PFX    = 14'b00000000100000,
    S_SCAT   = 14'b00000001000000,
    S_COPY   = 14'b00000010000000,
    S_RR     = 14'b00000100000000,
    S_RCOPY  = 14'b00001000000000,
    S_DONE   = 14'b00010000000000,
    S_CNT2   = 14'b00100000000000,
    S_SCAT2  = 14'b01000000000000,
    S_RR2    = 14'b10000000000000
  } state_t;

  state_t state;
  logic [8:0]  alphabet_size;
  logic [RW-1:0] loaded_count;
  logic text_closed, over;

  logic [RW-1:0] symbol_rank [MAX_TEXT];
  logic [AW-1:0] suffix_order [MAX_TEXT];
  logic [RW-1:0] scratch_store [MAX_TEXT];
  logic [RW-1:0] bucket_counts [MAX_TEXT+1];

  logic [RW-1:0] n, top, idx, sum, rank_r;
  logic [RW-1:0] k;
  logic pass2;       // second sort of the pass uses offset zero
  logic [1:0] ph;    // sub-step within a state
  logic [AW-1:0] ord_q;
  logic [RW-1:0] rk_q, rka_q, rkb_q, prev_a, prev_b, bk_q;

  logic [8:0] asz;
  assign asz = (alphabet_size == 9'd0) ? 9'd1 :
               (alphabet_size > 9'(MAX_ALPHABET)) ? 9'(MAX_ALPHABET) : alphabet_size;

  assign busy = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  logic [RW-1:0] off;
  assign off = pass2 ? '0 : k;

  // sum of order entry plus offset, compared against n for past-the-end
  logic [RW:0] tpos;
  assign tpos = {1'b0, RW'(ord_q)} + {1'b0, off};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      alphabet_size <= 9'd256;
      loaded_count <= '0;
      text_closed <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_valid) alphabet_size <= cfg_data;
      unique case (state)
        S_IDLE: if (start) begin
          if (req.req_type == REQ_READ) begin
            rsp.text_length <= loaded_count;
            rsp.suffix_start <= '0;
            if (!text_closed || {1'b0, req.position} >= loaded_count) begin
              rsp.status <= ST_BAD_POS;
              done <= 1'b1;
            end else begin
              ord_q <= suffix_order[req.position];
              state <= S_READ;
            end
          end else begin
            logic [RW-1:0] cnt;
            logic [7:0] s;
            cnt = text_closed ? '0 : loaded_count;
            text_closed <= 1'b0;
            s = ({1'b0, req.symbol_index} > asz - 9'd1) ? 8'(asz - 9'd1) : req.symbol_index;
            over <= (cnt >= RW'(MAX_TEXT));
            if (cnt < RW'(MAX_TEXT)) begin
              symbol_rank[cnt[AW-1:0]] <= RW'(s) + RW'(1);
              cnt = cnt + RW'(1);
            end
            loaded_count <= cnt;
            rsp.text_length <= cnt;
            rsp.suffix_start <= '0;
            if (req.is_last) begin
              n <= cnt;
              top <= ({2'b0, asz} > cnt) ? {2'b0, asz} : cnt;
              k <= RW'(1);
              idx <= '0;
              state <= S_INIT;
            end else if (cnt >= RW'(MAX_TEXT) && loaded_count >= RW'(MAX_TEXT)
                         && !text_closed) begin
              rsp.status <= ST_OVERFLOW;
              done <= 1'b1;
            end
          end
        end
        S_READ: begin
          rsp.suffix_start <= ord_q;
          rsp.status <= ST_READ_OK;
          done <= 1'b1;
          state <= S_IDLE;
        end
        S_INIT: begin
          // identity order
          if (idx >= n) begin
            idx <= '0; pass2 <= 1'b0;
            state <= (k < n) ? S_CLR : S_DONE;
          end else begin
            suffix_order[idx[AW-1:0]] <= idx[AW-1:0];
            idx <= idx + RW'(1);
          end
        end
        S_CLR: begin
          bucket_counts[idx] <= '0;
          if (idx == top) begin idx <= '0; ph <= 2'd0; state <= S_CNT; end
          else idx <= idx + RW'(1);
        end
        S_CNT: begin
          // fetch order entry, then its rank, then bump its bucket
          if (idx >= n) begin idx <= '0; sum <= '0; ph <= 2'd0; state <= S_PFX; end
          else begin
            ord_q <= suffix_order[idx[AW-1:0]];
            state <= S_CNT2; ph <= 2'd0;
          end
        end
        S_CNT2: begin
          unique case (ph)
            2'd0: begin
              rk_q <= (tpos < {1'b0, n}) ? symbol_rank[tpos[AW-1:0]] : '0;
              ph <= 2'd1;
            end
            2'd1: begin bk_q <= bucket_counts[rk_q]; ph <= 2'd2; end
            default: begin
              bucket_counts[rk_q] <= bk_q + RW'(1);
              idx <= idx + RW'(1);
              state <= S_CNT;
            end
          endcase
        end
        S_PFX: begin
          // exclusive prefix sum, a read and then a write per bucket
          if (ph == 2'd0) begin bk_q <= bucket_counts[idx]; ph <= 2'd1; end
          else begin
            bucket_counts[idx] <= sum;
            sum <= sum + bk_q;
            ph <= 2'd0;
            if (idx == top) begin idx <= '0; state <= S_SCAT; end
            else idx <= idx + RW'(1);
          end
        end
        S_SCAT: begin
          if (idx >= n) begin idx <= '0; ph <= 2'd0; state <= S_COPY; end
          else begin
            ord_q <= suffix_order[idx[AW-1:0]];
            ph <= 2'd0; state <= S_SCAT2;
          end
        end
        S_SCAT2: begin
          unique case (ph)
            2'd0: begin
              rk_q <= (tpos < {1'b0, n}) ? symbol_rank[tpos[AW-1:0]] : '0;
              ph <= 2'd1;
            end
            2'd1: begin bk_q <= bucket_counts[rk_q]; ph <= 2'd2; end
            default: begin
              scratch_store[bk_q[AW-1:0]] <= RW'(ord_q);
              bucket_counts[rk_q] <= bk_q + RW'(1);
              idx <= idx + RW'(1);
              state <= S_SCAT;
            end
          endcase
        end
        S_COPY: begin
          if (ph == 2'd0) begin
            if (idx >= n) begin
              idx <= '0;
              if (!pass2) begin pass2 <= 1'b1; state <= S_CLR; end
              else begin
                // re-rank looks at offset k again
                rank_r <= RW'(1); pass2 <= 1'b0; state <= S_RR;
              end
            end else begin rk_q <= scratch_store[idx[AW-1:0]]; ph <= 2'd1; end
          end else begin
            suffix_order[idx[AW-1:0]] <= rk_q[AW-1:0];
            idx <= idx + RW'(1); ph <= 2'd0;
          end
        end
        S_RR: begin
          // re-rank: read b, rank(b), rank(b+k), compare with previous
          if (idx >= n) begin idx <= '0; ph <= 2'd0; state <= S_RCOPY; end
          else begin
            ord_q <= suffix_order[idx[AW-1:0]];
            ph <= 2'd0; state <= S_RR2;
          end
        end
        S_RR2: begin
          unique case (ph)
            2'd0: begin rka_q <= symbol_rank[ord_q]; ph <= 2'd1; end
            2'd1: begin
              rkb_q <= (tpos < {1'b0, n}) ? symbol_rank[tpos[AW-1:0]] : '0;
              ph <= 2'd2;
            end
            default: begin
              logic [RW-1:0] r;
              r = rank_r;
              if (idx != '0 && (rka_q != prev_a || rkb_q != prev_b)) r = rank_r + RW'(1);
              rank_r <= r;
              scratch_store[ord_q] <= r;
              prev_a <= rka_q; prev_b <= rkb_q;
              idx <= idx + RW'(1);
              state <= S_RR;
            end
          endcase
        end
        S_RCOPY: begin
          if (ph == 2'd0) begin
            if (idx >= n) begin
              idx <= '0;
              if (rank_r == n || (k << 1) >= n) state <= S_DONE;
              else begin k <= k << 1; top <= n; pass2 <= 1'b0; state <= S_CLR; end
            end else begin rk_q <= scratch_store[idx[AW-1:0]]; ph <= 2'd1; end
          end else begin
            symbol_rank[idx[AW-1:0]] <= rk_q;
            idx <= idx + RW'(1); ph <= 2'd0;
          end
        end
        S_DONE: begin
          text_closed <= 1'b1;
          rsp.status <= over ? ST_OVERFLOW : ST_BUILD_DONE;
          rsp.suffix_start <= '0;
          rsp.text_length <= loaded_count;
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // offset doubles only inside a build
  a_k_pow2: assert property (@(posedge clk) disable iff (rst) $onehot(k) || state == S_IDLE
    || state == S_READ) else $error("offset not a power of two");
  // a result never overlaps further work in a read
  a_read_done: assert property (@(posedge clk) disable iff (rst)
    state == S_READ |=> done && state == S_IDLE) else $error("read result missing");
  // build result comes with the text closed
  a_close: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE |=> text_closed) else $error("text not closed after build");
endmodule
